FILE: rtl/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int unsigned CoordW   = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned LongW    = 16;
  localparam int unsigned EventW   = 4;
  localparam int unsigned QuadW    = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CoordW-1:0] ScreenSpan = 8'd240;
  localparam logic [CoordW-1:0] CentreLine = 8'd120;
  localparam logic [ThrW-1:0]   ThrReset   = 8'd50;
  localparam logic [LongW-1:0]  LongReset  = 16'd300;

  typedef enum logic [EventW-1:0] {
    EV_NONE        = 4'd0,
    EV_TOUCHED     = 4'd1,
    EV_HOLD        = 4'd2,
    EV_SWIPE_LEFT  = 4'd3,
    EV_SWIPE_RIGHT = 4'd4,
    EV_SWIPE_DOWN  = 4'd5,
    EV_SWIPE_UP    = 4'd6,
    EV_LONG_PRESS  = 4'd7,
    EV_CLICK       = 4'd8
  } event_e;

  typedef enum logic [QuadW-1:0] {
    QUAD_TL     = 3'd0,
    QUAD_TR     = 3'd1,
    QUAD_BL     = 3'd2,
    QUAD_BR     = 3'd3,
    QUAD_CENTRE = 3'd4
  } quadrant_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SWIPE_THRESHOLD = 1'b0,
    REG_LONG_PRESS_MS   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ThrW-1:0]  swipe_threshold;
    logic [LongW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic              contact;
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
    logic [TimeW-1:0]  now_ms;
  } sample_t;

  typedef struct packed {
    event_e            event_res;
    quadrant_e         quadrant;
    logic [CoordW-1:0] release_x;
    logic [CoordW-1:0] release_y;
  } result_t;

  function automatic quadrant_e quadrant_of(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    quadrant_e q;
    if (x < CentreLine && y < CentreLine) begin
      q = QUAD_TL;
    end else if (x > CentreLine && y < CentreLine) begin
      q = QUAD_TR;
    end else if (x < CentreLine && y > CentreLine) begin
      q = QUAD_BL;
    end else if (x > CentreLine && y > CentreLine) begin
      q = QUAD_BR;
    end else begin
      q = QUAD_CENTRE;
    end
    return q;
  endfunction

endpackage

FILE: rtl/tgc_if.sv
`timescale 1ns / 1ps

interface tgc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        contact;
  logic [tgc_pkg::CoordW-1:0]  raw_x;
  logic [tgc_pkg::CoordW-1:0]  raw_y;
  logic [tgc_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, contact, raw_x, raw_y, now_ms, input ready);
  modport sink   (input valid, contact, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgc_pkg::EventW-1:0]  event_res;
  logic [tgc_pkg::QuadW-1:0]   quadrant;
  logic [tgc_pkg::CoordW-1:0]  release_x;
  logic [tgc_pkg::CoordW-1:0]  release_y;

  modport source (output valid, event_res, quadrant, release_x, release_y, input ready);
  modport sink   (input valid, event_res, quadrant, release_x, release_y, output ready);
endinterface

interface tgc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::CfgIdxW-1:0]  index;
  logic [tgc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tgc_cfg_regs.sv
`timescale 1ns / 1ps

module tgc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  tgc_cfg_if.sink        cfg_i,
  output tgc_pkg::cfg_t  cfg_o
);

  tgc_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (tgc_pkg::cfg_reg_e'(cfg_i.index))
        tgc_pkg::REG_SWIPE_THRESHOLD: begin
          cfg_d.swipe_threshold = cfg_i.data[tgc_pkg::ThrW-1:0];
        end
        tgc_pkg::REG_LONG_PRESS_MS: begin
          cfg_d.long_press_ms = cfg_i.data[tgc_pkg::LongW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swipe_threshold <= tgc_pkg::ThrReset;
      cfg_q.long_press_ms   <= tgc_pkg::LongReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/tgc_core.sv
`timescale 1ns / 1ps

module tgc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgc_pkg::sample_t  sample_i,
  input  logic              load_i,
  input  tgc_pkg::cfg_t     cfg_i,
  output tgc_pkg::result_t  result_o
);

  logic                        touching_q, touching_d;
  logic [tgc_pkg::TimeW-1:0]   press_time_q, press_time_d;
  logic [tgc_pkg::CoordW-1:0]  start_x_q, start_x_d;
  logic [tgc_pkg::CoordW-1:0]  start_y_q, start_y_d;
  logic [tgc_pkg::CoordW-1:0]  last_x_q, last_x_d;
  logic [tgc_pkg::CoordW-1:0]  last_y_q, last_y_d;

  logic [tgc_pkg::CoordW-1:0]  x;
  logic signed [tgc_pkg::CoordW+1:0] dx, dy, thr;
  logic [tgc_pkg::TimeW-1:0]   held;
  logic                        long_held;
  tgc_pkg::event_e             release_ev, ev;

  // A raw x beyond the panel span mirrors to the left edge.
  assign x = (sample_i.raw_x > tgc_pkg::ScreenSpan) ? '0
                                                    : tgc_pkg::ScreenSpan - sample_i.raw_x;

  assign dx   = $signed({2'b00, x}) - $signed({2'b00, start_x_q});
  assign dy   = $signed({2'b00, sample_i.raw_y}) - $signed({2'b00, start_y_q});
  assign thr  = $signed({2'b00, cfg_i.swipe_threshold});
  assign held = sample_i.now_ms - press_time_q;
  assign long_held = held > {{(tgc_pkg::TimeW-tgc_pkg::LongW){1'b0}}, cfg_i.long_press_ms};

  always_comb begin
    if (dx > thr) begin
      release_ev = tgc_pkg::EV_SWIPE_LEFT;
    end else if (dx < -thr) begin
      release_ev = tgc_pkg::EV_SWIPE_RIGHT;
    end else if (dy > thr) begin
      release_ev = tgc_pkg::EV_SWIPE_DOWN;
    end else if (dy < -thr) begin
      release_ev = tgc_pkg::EV_SWIPE_UP;
    end else if (long_held) begin
      release_ev = tgc_pkg::EV_LONG_PRESS;
    end else begin
      release_ev = tgc_pkg::EV_CLICK;
    end
  end

  always_comb begin
    touching_d   = touching_q;
    press_time_d = press_time_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    ev           = tgc_pkg::EV_NONE;
    if (sample_i.contact && !touching_q) begin
      touching_d   = 1'b1;
      press_time_d = sample_i.now_ms;
      start_x_d    = x;
      start_y_d    = sample_i.raw_y;
      ev           = tgc_pkg::EV_TOUCHED;
    end else if (sample_i.contact) begin
      ev = tgc_pkg::EV_HOLD;
    end else if (touching_q) begin
      touching_d = 1'b0;
      last_x_d   = x;
      last_y_d   = sample_i.raw_y;
      ev         = release_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q   <= 1'b0;
      press_time_q <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
    end else if (load_i) begin
      touching_q   <= touching_d;
      press_time_q <= press_time_d;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
    end
  end

  assign result_o.event_res = ev;
  assign result_o.quadrant  = tgc_pkg::quadrant_of(last_x_d, last_y_d);
  assign result_o.release_x = last_x_d;
  assign result_o.release_y = last_y_d;

endmodule

FILE: rtl/touch_gesture_classifier.sv
`timescale 1ns / 1ps

// Touch gesture classifier. Each transfer on in_i carries one controller
// sample (contact flag, raw coordinates, millisecond timestamp); each sample
// yields exactly one transfer on out_o with the gesture event, the quadrant of
// the last release point and that point itself.
// A sample is held in an input register and classified once the output
// register is empty or its result is being transferred, when the result,
// together with the updated touch state, is written to the output register.
// One sample can be taken in every cycle while the receiver keeps
// out_o.ready high.
// The input register accepts a new sample while the output register still
// waits for its transfer, as long as the input register is empty; when
// the receiver holds out_o.ready low, the result stays, the input register
// fills and in_i.ready then drops until the output drains.
// cfg_i writes the swipe threshold (index 0) and the long-press limit
// (index 1); it is always ready and should only be used while the block is
// idle. Reset clears both pipeline stages and the touch state and restores
// the threshold to 50 pixels and the limit to 300 ms.
module touch_gesture_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgc_in_if.sink     in_i,
  tgc_out_if.source  out_o,
  tgc_cfg_if.sink    cfg_i
);

  tgc_pkg::cfg_t     cfg;
  tgc_pkg::sample_t  s1_q, s1_d;
  logic              s1_valid_q;
  tgc_pkg::result_t  result, out_q;
  logic              out_valid_q;
  logic              out_load;
  logic              in_load;

  assign out_load = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_load    = in_i.valid && in_i.ready;

  assign s1_d.contact = in_i.contact;
  assign s1_d.raw_x   = in_i.raw_x;
  assign s1_d.raw_y   = in_i.raw_y;
  assign s1_d.now_ms  = in_i.now_ms;

  tgc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tgc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (s1_q),
    .load_i   (out_load),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_q <= s1_d;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_q.event_res;
  assign out_o.quadrant  = out_q.quadrant;
  assign out_o.release_x = out_q.release_x;
  assign out_o.release_y = out_q.release_y;

endmodule

FILE: rtl/tgc_checker.sv
`timescale 1ns / 1ps

module tgc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tgc_pkg::EventW-1:0]  event_res_i,
  input logic [tgc_pkg::QuadW-1:0]   quadrant_i,
  input logic [tgc_pkg::CoordW-1:0]  release_x_i,
  input logic [tgc_pkg::CoordW-1:0]  release_y_i
);

  // A stalled result must not change until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_res_i)
      && $stable(quadrant_i) && $stable(release_x_i) && $stable(release_y_i))
    else $error("stalled result changed");

  // Events are within the defined codes and the mirrored x never leaves the panel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_res_i <= tgc_pkg::EV_CLICK && release_x_i <= tgc_pkg::ScreenSpan)
    else $error("result field out of range");

  // The reported quadrant must agree with the reported release point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((release_x_i == tgc_pkg::CentreLine || release_y_i == tgc_pkg::CentreLine)
         && quadrant_i == tgc_pkg::QUAD_CENTRE)
      || (release_x_i < tgc_pkg::CentreLine && release_y_i < tgc_pkg::CentreLine
         && quadrant_i == tgc_pkg::QUAD_TL)
      || (release_x_i > tgc_pkg::CentreLine && release_y_i < tgc_pkg::CentreLine
         && quadrant_i == tgc_pkg::QUAD_TR)
      || (release_x_i < tgc_pkg::CentreLine && release_y_i > tgc_pkg::CentreLine
         && quadrant_i == tgc_pkg::QUAD_BL)
      || (release_x_i > tgc_pkg::CentreLine && release_y_i > tgc_pkg::CentreLine
         && quadrant_i == tgc_pkg::QUAD_BR))
    else $error("quadrant does not match release point");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .event_res_i (out_o.event_res),
  .quadrant_i  (out_o.quadrant),
  .release_x_i (out_o.release_x),
  .release_y_i (out_o.release_y)
);
